### rtl/srdt_pkg.sv
// ----------------------------------------------------------------------------
// srdt_pkg: shared definitions of the sorted round-robin delegate table
// Table depth, derived widths, command and status codes, and the request and
// response records that pass between the top level and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package srdt_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam int IdW    = 22;
  localparam int JobW   = 32;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;
  localparam int EcntW  = 5;
  localparam int IdxW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PtrW   = IdxW;
  localparam int CntW   = $clog2(TABLE_DEPTH + 1);

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_POST   = 2'd2;
  localparam logic [CmdW-1:0] CMD_TAKE   = 2'd3;

  localparam logic [StatW-1:0] STAT_DONE    = 2'd0;
  localparam logic [StatW-1:0] STAT_NOMATCH = 2'd1;
  localparam logic [StatW-1:0] STAT_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } srdt_op_e;

  typedef struct packed {
    logic             start;
    srdt_op_e         op;
    logic [IdW-1:0]   id;
    logic [CntW-1:0]  cnt;
    logic [PtrW-1:0]  ptr;
  } srdt_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [CntW-1:0]  pos;
  } srdt_rsp_t;

endpackage

`default_nettype wire

### rtl/srdt_engine.sv
// ----------------------------------------------------------------------------
// srdt_engine: id table storage with its search and shift sequencer
// One comparator walks the stored ids, one entry per cycle, and the same
// memory port pair moves entries up or down to open or close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module srdt_engine
  import srdt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire srdt_req_t req_i,
  output      srdt_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_SRCH,
    E_SHUP,
    E_SHDN,
    E_PUT,
    E_CHK,
    E_DONE
  } eng_state_e;

  eng_state_e      state_q, state_d;
  srdt_op_e        op_q, op_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cidx_q, cidx_d;
  logic [CntW-1:0] widx_q, widx_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            found_q, found_d;

  logic [IdW-1:0]  mem_q [TABLE_DEPTH];
  logic [IdW-1:0]  rdata_q;
  logic            ren, we;
  logic [IdxW-1:0] raddr, waddr;
  logic [IdW-1:0]  wdata;

  logic            cmp_gt, cmp_eq, hit;
  logic [CntW-1:0] hit_pos;

  // The single shared comparator.
  assign cmp_gt = rdata_q > id_q;
  assign cmp_eq = rdata_q == id_q;
  assign hit    = (op_q == OP_INSERT) ? cmp_gt : cmp_eq;
  assign hit_pos = hit ? cidx_q : cnt_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    id_d    = id_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cidx_d  = cidx_q;
    widx_d  = widx_q;
    pos_d   = pos_q;
    found_d = found_q;
    ren     = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = rdata_q;
    case (state_q)
      E_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          id_d    = req_i.id;
          cnt_d   = req_i.cnt;
          found_d = 1'b0;
          if (req_i.op == OP_READ) begin
            ren     = 1'b1;
            raddr   = req_i.ptr;
            state_d = E_CHK;
          end else if (req_i.cnt == '0) begin
            pos_d   = '0;
            state_d = (req_i.op == OP_INSERT) ? E_PUT : E_DONE;
          end else begin
            ren     = 1'b1;
            raddr   = '0;
            cidx_d  = '0;
            idx_d   = CntW'(1);
            state_d = E_SRCH;
          end
        end
      end
      E_SRCH: begin
        if (hit || idx_q == cnt_q) begin
          pos_d   = hit_pos;
          found_d = hit;
          if (op_q == OP_INSERT) begin
            if (hit_pos == cnt_q) begin
              state_d = E_PUT;
            end else begin
              ren     = 1'b1;
              raddr   = cnt_q[IdxW-1:0] - IdxW'(1);
              widx_d  = cnt_q;
              state_d = E_SHUP;
            end
          end else if (hit && (cidx_q + CntW'(1) < cnt_q)) begin
            ren     = 1'b1;
            raddr   = cidx_q[IdxW-1:0] + IdxW'(1);
            widx_d  = cidx_q;
            state_d = E_SHDN;
          end else begin
            state_d = E_DONE;
          end
        end else begin
          ren    = 1'b1;
          raddr  = idx_q[IdxW-1:0];
          cidx_d = idx_q;
          idx_d  = idx_q + CntW'(1);
        end
      end
      E_SHUP: begin
        we    = 1'b1;
        waddr = widx_q[IdxW-1:0];
        if (widx_q - CntW'(1) > pos_q) begin
          ren    = 1'b1;
          raddr  = widx_q[IdxW-1:0] - IdxW'(2);
          widx_d = widx_q - CntW'(1);
        end else begin
          state_d = E_PUT;
        end
      end
      E_SHDN: begin
        we    = 1'b1;
        waddr = widx_q[IdxW-1:0];
        if (widx_q + CntW'(2) < cnt_q) begin
          ren    = 1'b1;
          raddr  = widx_q[IdxW-1:0] + IdxW'(2);
          widx_d = widx_q + CntW'(1);
        end else begin
          state_d = E_DONE;
        end
      end
      E_PUT: begin
        we      = 1'b1;
        waddr   = pos_q[IdxW-1:0];
        wdata   = id_q;
        state_d = E_DONE;
      end
      E_CHK: begin
        found_d = cmp_eq;
        state_d = E_DONE;
      end
      E_DONE: begin
        state_d = E_IDLE;
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    cidx_q <= cidx_d;
    widx_q <= widx_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rsp_o.done  = (state_q == E_DONE);
  assign rsp_o.found = found_q;
  assign rsp_o.pos   = pos_q;

  // A shift never reads the entry it writes in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && ren) |-> (waddr != raddr))
    else $error("srdt_engine: read and write of the same entry in one cycle");

  // An insert never shifts beyond the last storage entry.
  a_shup_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_SHUP) |-> (widx_q < CntW'(TABLE_DEPTH)))
    else $error("srdt_engine: shift up past the end of the table");

  // A new request only arrives while the sequencer is idle.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == E_IDLE))
    else $error("srdt_engine: request while busy");

endmodule

`default_nettype wire

### rtl/sorted_round_robin_delegate_table.sv
// ----------------------------------------------------------------------------
// sorted_round_robin_delegate_table: sorted worker table with turn pointer
// Post and refused commands settle without the engine; take, insert and delete
// wait on it, insert and delete for as long as it compares and shifts entries.
// A new transfer is taken only once the last result has moved to the output
// register, which waits while an earlier result is unaccepted; the engine's
// single read and compare port sets the pace of the table commands.
// Reset clears count, pointer, job slot and handshakes; id storage is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_round_robin_delegate_table
  import srdt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [CmdW-1:0]  command_i,
  input  wire logic [IdW-1:0]   worker_id_i,
  input  wire logic [JobW-1:0]  job_word_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [StatW-1:0] status_o,
  output      logic [JobW-1:0]  job_out_o,
  output      logic [EcntW-1:0] entry_count_o
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_OUT
  } top_state_e;

  // Control state and the architectural state of the table.
  top_state_e       state_q, state_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [JobW-1:0]  store_q, store_d;

  // Result waiting for the output register, and the output register itself.
  logic [StatW-1:0] res_status_q, res_status_d;
  logic [JobW-1:0]  res_job_q, res_job_d;
  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] status_q, status_d;
  logic [JobW-1:0]  job_out_q, job_out_d;
  logic [EcntW-1:0] ecnt_q, ecnt_d;

  srdt_req_t        req;
  srdt_rsp_t        rsp;

  logic             accept;
  logic [CntW-1:0]  ptr_ext;
  logic [CntW-1:0]  cnt_less;
  logic [CntW-1:0]  ptr_after_del;
  logic [CntW-1:0]  ptr_next;

  srdt_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // New commands are taken whenever no command is in work; the output
  // register keeps any earlier result on its own side.
  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign ptr_ext  = CntW'(ptr_q);
  assign cnt_less = cnt_q - CntW'(1);
  // Deleting an entry below the pointer pulls the pointer down with it.
  assign ptr_after_del = (rsp.pos < ptr_ext) ? (ptr_ext - CntW'(1)) : ptr_ext;
  assign ptr_next      = ptr_ext + CntW'(1);

  // Engine request: only commands that must look into the id storage go out.
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_INSERT;
    req.id    = worker_id_i;
    req.cnt   = cnt_q;
    req.ptr   = ptr_q;
    if (accept) begin
      case (command_i)
        CMD_INSERT: begin
          req.start = (cnt_q < CntW'(TABLE_DEPTH));
          req.op    = OP_INSERT;
        end
        CMD_DELETE: begin
          req.start = (cnt_q != '0);
          req.op    = OP_DELETE;
        end
        CMD_TAKE: begin
          req.start = (cnt_q != '0) && pend_q;
          req.op    = OP_READ;
        end
        default: begin
          req.start = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    store_d      = store_q;
    res_status_d = res_status_q;
    res_job_d    = res_job_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    job_out_d    = job_out_q;
    ecnt_d       = ecnt_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          cmd_d        = command_i;
          res_job_d    = '0;
          res_status_d = STAT_DONE;
          if (req.start) begin
            state_d = T_BUSY;
          end else begin
            // Commands settled without the table: refusals, absent delete
            // on an empty table, and posting.
            state_d = T_OUT;
            case (command_i)
              CMD_INSERT: res_status_d = STAT_REFUSED;
              CMD_DELETE: res_status_d = STAT_NOMATCH;
              CMD_POST: begin
                if ((cnt_q == '0) || pend_q) begin
                  res_status_d = STAT_REFUSED;
                end else begin
                  store_d = job_word_i;
                  pend_d  = 1'b1;
                end
              end
              default: res_status_d = STAT_REFUSED;
            endcase
          end
        end
      end
      T_BUSY: begin
        if (rsp.done) begin
          state_d = T_OUT;
          case (cmd_q)
            CMD_INSERT: begin
              // Keep the pointer on the same holder; the first id goes to 0.
              if (cnt_q == '0) begin
                ptr_d = '0;
              end else if (rsp.pos <= ptr_ext) begin
                ptr_d = PtrW'(ptr_next);
              end
              cnt_d = cnt_q + CntW'(1);
            end
            CMD_DELETE: begin
              if (!rsp.found) begin
                res_status_d = STAT_NOMATCH;
              end else begin
                cnt_d = cnt_less;
                // The pointer wraps to 0 once it falls off the end.
                if (ptr_after_del >= cnt_less) begin
                  ptr_d = '0;
                end else begin
                  ptr_d = PtrW'(ptr_after_del);
                end
              end
            end
            default: begin
              if (!rsp.found) begin
                res_status_d = STAT_NOMATCH;
              end else begin
                res_job_d = store_q;
                pend_d    = 1'b0;
                store_d   = '0;
                ptr_d     = (ptr_next >= cnt_q) ? '0 : PtrW'(ptr_next);
              end
            end
          endcase
        end
      end
      T_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          job_out_d   = res_job_q;
          ecnt_d      = EcntW'(cnt_q);
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      store_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      store_q     <= store_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    res_status_q <= res_status_d;
    res_job_q    <= res_job_d;
    status_q     <= status_d;
    job_out_q    <= job_out_d;
    ecnt_q       <= ecnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign job_out_o     = job_out_q;
  assign entry_count_o = ecnt_q;

  // While ids are held, the pointer names one of them.
  a_ptr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (ptr_ext < cnt_q))
    else $error("top: turn pointer beyond the occupied entries");

  // The table never holds more ids than it has entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_DEPTH))
    else $error("top: entry count above table depth");

  // An empty job slot always holds a zero word.
  a_slot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> (store_q == '0))
    else $error("top: empty job slot holds a stale word");

  // The engine reports completion only for a command that is waiting on it.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == T_BUSY))
    else $error("top: engine completion without a command in work");

endmodule

`default_nettype wire
